// ===== hw/rtl/avs_pkg.sv =====
`default_nettype none

package avs_pkg;

   // default store capacity
   localparam int MAX_ITEMS_DEFAULT = 32;
   localparam int VALUE_W           = 32;

   typedef enum logic [0:0] {
      ST_COLLECT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sorted_value;
      logic                      end_of_run;
      logic                      overflowed;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic insert;
      logic set_ovf;
      logic shift;
      logic clear;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic last_one;
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/avs_datapath.sv =====
`default_nettype none

module avs_datapath
   import avs_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cmd_type                   cmd,
   input  wire logic signed [VALUE_W-1:0] in_value,
   output      status_type                status,
   output      rsp_type                   rsp_data
);

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   logic signed [VALUE_W-1:0] cell_ff [MAX_ITEMS];
   logic signed [VALUE_W-1:0] cell_in [MAX_ITEMS];
   logic        [MAX_ITEMS-1:0] lt;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;

   // per-cell compare; empty cells act as larger than anything
   always_comb begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
         lt[i] = (CNT_W'(i) >= count_ff) || (in_value < cell_ff[i]);
      end
   end

   // insertion chain on insert, shift toward cell 0 on emit
   always_comb begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
         cell_in[i] = cell_ff[i];
         if (cmd.insert) begin
            if (i > 0 && lt[(i > 0) ? i - 1 : 0]) begin
               cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
            end else if (lt[i]) begin
               cell_in[i] = in_value;
            end
         end else if (cmd.shift && i < MAX_ITEMS - 1) begin
            cell_in[i] = cell_ff[(i < MAX_ITEMS - 1) ? i + 1 : i];
         end
      end
   end

   // hold the cells
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   // track fill count and overflow flag
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cmd.clear) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end else begin
         if (cmd.insert) begin
            count_in = count_ff + CNT_W'(1);
         end else if (cmd.shift) begin
            count_in = count_ff - CNT_W'(1);
         end
         if (cmd.set_ovf) begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign status.full     = (count_ff == CNT_W'(MAX_ITEMS));
   assign status.last_one = (count_ff == CNT_W'(1));

   assign rsp_data.sorted_value = cell_ff[0];
   assign rsp_data.end_of_run   = status.last_one;
   assign rsp_data.overflowed   = ovf_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/avs_ctrl.sv =====
`default_nettype none

module avs_ctrl
   import avs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic       in_last,
   input  wire status_type status,
   output      cmd_type    cmd,
   output      logic       busy,
   output      logic       emit
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b0;
      emit     = 1'b0;
      unique case (state_ff)
         ST_COLLECT: begin
            if (start) begin
               // drop the beat when the store is full
               cmd.insert  = !status.full;
               cmd.set_ovf = status.full;
               if (in_last) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            busy      = 1'b1;
            emit      = 1'b1;
            cmd.shift = 1'b1;
            if (status.last_one) begin
               cmd.clear = 1'b1;
               state_in  = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ascending_value_sorter_top.sv =====
// Collect: one beat per cycle unless busy, inserted into the sorted chain in the cycle it is taken.
// After a beat with last set, N results (N = stored count) stream out on consecutive
// cycles, the first in the cycle after that beat; busy stays high while they stream out.
// Results cannot be stalled by the receiver; each rsp_strobe cycle is one result.
// Synchronous reset empties the store, clears the overflow flag and returns to collect.
`default_nettype none

module ascending_value_sorter_top
   import avs_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output      logic    busy,
   input  wire req_type req_data,
   output      logic    rsp_strobe,
   output      rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   avs_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .in_last (req_data.last),
      .status  (status),
      .cmd     (cmd),
      .busy    (busy),
      .emit    (rsp_strobe)
   );

   avs_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .in_value (req_data.value),
      .status   (status),
      .rsp_data (rsp_data)
   );

   // results come out in ascending order
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.end_of_run |=>
         $signed(rsp_data.sorted_value) >= $signed($past(rsp_data.sorted_value)))
      else $error("sorter output not ascending");

   // a last beat starts the stream on the next cycle
   a_stream_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.last |=> rsp_strobe)
      else $error("no result after last beat");

   // the stream runs without gaps until the end marker
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.end_of_run |=> rsp_strobe)
      else $error("gap in result stream");

   // the end marker frees the block
   a_release: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.end_of_run |=> !busy)
      else $error("busy after end of run");

endmodule

`default_nettype wire

// ===== test/tb_ascending_value_sorter_top.sv =====
`timescale 1ns / 100ps

module tb_ascending_value_sorter_top;
   import avs_pkg::*;

   localparam int CAPACITY     = MAX_ITEMS_DEFAULT;
   localparam int RANDOM_BEATS = 500;
   localparam int DIR_ROWS     = 21;

   localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   // one beat of stimulus; literal rows carry their one expected result
   typedef struct packed {
      req_type beat;
      logic    literal;
      rsp_type want;
   } stim_row_type;

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    start      = 1'b0;
   req_type req_data   = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // sorted-store predictor state
   logic signed [VALUE_W-1:0] sorted_store [0:CAPACITY-1];
   int                        stored_count = 0;
   bit                        dropped_seen = 1'b0;
   rsp_type                   sorted_queue [$];
   stim_row_type              presented_rows [$];
   stim_row_type              dir_table [0:DIR_ROWS-1];
   int                        mismatch_count = 0;

   ascending_value_sorter_top #(
      .MAX_ITEMS(CAPACITY)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // hard limit on run time
   initial begin
      #2_000_000;
      $display("** ascending_value_sorter_top: FAILED **");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic stim_row_type make_row(logic signed [VALUE_W-1:0] v, logic l,
                                             logic lit, logic signed [VALUE_W-1:0] ev,
                                             logic ee, logic eo);
      stim_row_type r;
      r.beat.value        = v;
      r.beat.last         = l;
      r.literal           = lit;
      r.want.sorted_value = ev;
      r.want.end_of_run   = ee;
      r.want.overflowed   = eo;
      return r;
   endfunction

   // insert one beat into the sorted store; on last, queue the sorted run
   function automatic void absorb_beat(req_type b);
      int      pos;
      rsp_type r;
      if (stored_count < CAPACITY) begin
         pos = stored_count;
         while (pos > 0 && $signed(b.value) < sorted_store[pos-1]) begin
            sorted_store[pos] = sorted_store[pos-1];
            pos--;
         end
         sorted_store[pos] = b.value;
         stored_count++;
      end else begin
         dropped_seen = 1'b1;
      end
      if (b.last) begin
         for (int i = 0; i < stored_count; i++) begin
            r.sorted_value = sorted_store[i];
            r.end_of_run   = (i + 1 == stored_count);
            r.overflowed   = dropped_seen;
            sorted_queue = {sorted_queue, r};
         end
         stored_count = 0;
         dropped_seen = 1'b0;
      end
   endfunction

   // random value: wide, clustered for duplicates, or an extreme
   function automatic logic signed [VALUE_W-1:0] pick_value();
      logic signed [VALUE_W-1:0] v;
      case ($urandom_range(3))
         0: v = $urandom_range(8) - 4;
         1: begin
            case ($urandom_range(3))
               0: v = VAL_MIN;
               1: v = VAL_MAX;
               2: v = '0;
               default: v = '1;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // present one beat, idling first at random; returns at the accepting edge
   task automatic drive_beat(input stim_row_type row, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      presented_rows = {presented_rows, row};
      start    <= 1'b1;
      req_data <= row.beat;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // sample acceptance and results at each edge
   always @(posedge clock) begin
      stim_row_type row;
      rsp_type      want;
      if (!reset) begin
         if (start && !busy) begin
            row = presented_rows.pop_front();
            absorb_beat(req_data);
            if (row.literal) begin
               sorted_queue[sorted_queue.size()-1] = row.want;
            end
         end
         if (rsp_strobe) begin
            if (sorted_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected result value %0d", rsp_data.sorted_value));
            end else begin
               want = sorted_queue.pop_front();
               if (rsp_data.sorted_value !== want.sorted_value)
                  report_mismatch($sformatf("sorted_value %0d, want %0d",
                                            rsp_data.sorted_value, want.sorted_value));
               if (rsp_data.end_of_run !== want.end_of_run)
                  report_mismatch($sformatf("end_of_run %b, want %b",
                                            rsp_data.end_of_run, want.end_of_run));
               if (rsp_data.overflowed !== want.overflowed)
                  report_mismatch($sformatf("overflowed %b, want %b",
                                            rsp_data.overflowed, want.overflowed));
            end
         end
      end
   end

   initial begin
      int                        sent;
      int                        seq_len;
      int                        idle_pct;
      stim_row_type              row;

      // single-beat runs come back unchanged
      dir_table[0]  = make_row('0,        1'b1, 1'b1, '0,        1'b1, 1'b0);
      dir_table[1]  = make_row(VAL_MAX,   1'b1, 1'b1, VAL_MAX,   1'b1, 1'b0);
      dir_table[2]  = make_row(VAL_MIN,   1'b1, 1'b1, VAL_MIN,   1'b1, 1'b0);
      dir_table[3]  = make_row('1,        1'b1, 1'b1, '1,        1'b1, 1'b0);
      dir_table[4]  = make_row(32'sd1,    1'b1, 1'b1, 32'sd1,    1'b1, 1'b0);
      // mixed run with extremes and an equal pair
      dir_table[5]  = make_row(32'sd5,    1'b0, 1'b0, '0, 1'b0, 1'b0);
      dir_table[6]  = make_row(-32'sd3,   1'b0, 1'b0, '0, 1'b0, 1'b0);
      dir_table[7]  = make_row(VAL_MAX,   1'b0, 1'b0, '0, 1'b0, 1'b0);
      dir_table[8]  = make_row(VAL_MIN,   1'b0, 1'b0, '0, 1'b0, 1'b0);
      dir_table[9]  = make_row(32'sd5,    1'b1, 1'b0, '0, 1'b0, 1'b0);
      // descending run
      dir_table[10] = make_row(32'sd3,    1'b0, 1'b0, '0, 1'b0, 1'b0);
      dir_table[11] = make_row(32'sd2,    1'b0, 1'b0, '0, 1'b0, 1'b0);
      dir_table[12] = make_row(32'sd1,    1'b0, 1'b0, '0, 1'b0, 1'b0);
      dir_table[13] = make_row(32'sd0,    1'b1, 1'b0, '0, 1'b0, 1'b0);
      // all equal
      dir_table[14] = make_row(32'sd7,    1'b0, 1'b0, '0, 1'b0, 1'b0);
      dir_table[15] = make_row(32'sd7,    1'b0, 1'b0, '0, 1'b0, 1'b0);
      dir_table[16] = make_row(32'sd7,    1'b1, 1'b0, '0, 1'b0, 1'b0);
      // pairs around zero and alternating bit patterns
      dir_table[17] = make_row('1,        1'b0, 1'b0, '0, 1'b0, 1'b0);
      dir_table[18] = make_row(32'sd1,    1'b1, 1'b0, '0, 1'b0, 1'b0);
      dir_table[19] = make_row(32'h5555_5555, 1'b0, 1'b0, '0, 1'b0, 1'b0);
      dir_table[20] = make_row(32'hAAAA_AAAA, 1'b1, 1'b0, '0, 1'b0, 1'b0);

      // hold reset, then release
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      for (int i = 0; i < DIR_ROWS; i++) begin
         drive_beat(dir_table[i], 31);
      end

      // random runs: mostly short, some past capacity
      sent = 0;
      while (sent < RANDOM_BEATS) begin
         if ($urandom_range(9) < 8)
            seq_len = $urandom_range(8, 1);
         else
            seq_len = $urandom_range(40, CAPACITY - 2);
         for (int k = 0; k < seq_len; k++) begin
            if (sent < RANDOM_BEATS / 3)
               idle_pct = 31;
            else if (sent < 2 * RANDOM_BEATS / 3)
               idle_pct = 83;
            else
               idle_pct = 0;
            row = make_row(pick_value(), (k == seq_len - 1), 1'b0, '0, 1'b0, 1'b0);
            drive_beat(row, idle_pct);
            sent++;
         end
      end
      start <= 1'b0;

      // drain outstanding results, then settle
      while (sorted_queue.size() != 0) @(posedge clock);
      repeat (2 * CAPACITY) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("** ascending_value_sorter_top: PASSED **");
      end else begin
         $display("** ascending_value_sorter_top: FAILED **");
      end
      $finish;
   end

endmodule
